/* rtl/core/sfb_pkg.sv */
// shared types, constants and helpers of the sprite frame blitter
package sfb_pkg;

  localparam int SCREEN_WIDTH     = 1024;
  localparam int SCREEN_HEIGHT    = 1024;
  localparam int SHEET_HEIGHT_MAX = 1024;

  localparam int ADDR_W   = 20;
  localparam int PIXEL_W  = 32;
  localparam int POS_W    = 12;
  localparam int FIDX_W   = 10;
  localparam int SIZE_W   = 11;
  localparam int WALK_W   = 10;
  localparam int COORD_W  = 14;
  localparam int ALPHA_LSB = 24;
  localparam int WALK_MAX = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_POS_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_WIDTH  = 3'd6;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } sfb_op_e;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [FIDX_W-1:0] frame_col;
    logic [FIDX_W-1:0] frame_row;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [SIZE_W-1:0] sheet_width;
  } sfb_cfg_t;

  // one classified item on its way to the address back end
  typedef struct packed {
    logic               has_src;
    logic [WALK_W-1:0]  col;
    logic [WALK_W-1:0]  row;
    logic               we;
    logic [ADDR_W-1:0]  dest;
    logic [PIXEL_W-1:0] colour;
    logic               last;
  } sfb_item_t;

  // zero counts as one, anything above the walk range as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(WALK_MAX)) begin
      r = SIZE_W'(WALK_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/sfb_front.sv */
// front end: takes items, walks the frame, clips and keys each pixel
module sfb_front
  import sfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfb_cfg_t  cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      in_opcode_i,
  input  logic [PIXEL_W-1:0] in_pixel_i,
  output logic      push_o,
  output sfb_item_t push_item_o,
  input  logic      full_i
);

  logic [WALK_W-1:0] col_q, col_d;
  logic [WALK_W-1:0] row_q, row_d;
  logic              busy_q, busy_d;

  logic                accept;
  logic [SIZE_W-1:0]   fw, fh;
  logic [SIZE_W-1:0]   col_inc;
  logic [WALK_W-1:0]   row_inc;
  logic                row_wrap;
  logic                is_last;
  logic signed [COORD_W-1:0] x, y;
  logic                on_screen, opaque;
  logic [ADDR_W-1:0]   dest;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  assign fw = clamp_size(cfg_i.frame_width);
  assign fh = clamp_size(cfg_i.frame_height);

  assign x = COORD_W'($signed(cfg_i.pos_x)) + $signed({{(COORD_W-WALK_W){1'b0}}, col_q});
  assign y = COORD_W'($signed(cfg_i.pos_y)) + $signed({{(COORD_W-WALK_W){1'b0}}, row_q});

  assign on_screen = !x[COORD_W-1] && (x[COORD_W-2:0] < (COORD_W-1)'(SCREEN_WIDTH))
                  && !y[COORD_W-1] && (y[COORD_W-2:0] < (COORD_W-1)'(SCREEN_HEIGHT));
  assign opaque    = in_pixel_i[PIXEL_W-1:ALPHA_LSB] != '0;
  assign dest      = ADDR_W'(x[COORD_W-2:0]) + ADDR_W'(y[COORD_W-2:0]) * ADDR_W'(SCREEN_WIDTH);

  assign col_inc  = {1'b0, col_q} + SIZE_W'(1);
  assign row_wrap = col_inc >= fw;
  assign row_inc  = row_q + WALK_W'(1);
  assign is_last  = row_wrap && ((row_inc == '0) || ({1'b0, row_inc} >= fh));

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    busy_d      = busy_q;
    push_item_o = '0;
    if (accept) begin
      unique case (sfb_op_e'(in_opcode_i))
        OP_START: begin
          col_d               = '0;
          row_d               = '0;
          busy_d              = 1'b1;
          push_item_o.has_src = 1'b1;
        end
        OP_PIXEL: begin
          if (busy_q) begin
            push_item_o.we     = on_screen && opaque;
            push_item_o.dest   = (on_screen && opaque) ? dest : '0;
            push_item_o.colour = in_pixel_i;
            if (is_last) begin
              col_d            = '0;
              row_d            = '0;
              busy_d           = 1'b0;
              push_item_o.last = 1'b1;
            end else begin
              col_d               = row_wrap ? '0 : col_inc[WALK_W-1:0];
              row_d               = row_wrap ? row_inc : row_q;
              push_item_o.has_src = 1'b1;
              push_item_o.col     = col_d;
              push_item_o.row     = row_d;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      busy_q <= busy_d;
    end
  end

  a_start_clears_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_opcode_i == OP_START) |=> (busy_q && col_q == '0 && row_q == '0))
    else $error("start item did not reset the walk");

  a_last_ends_blit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_item_o.last) |=> !busy_q)
    else $error("block still busy after the last pixel");

  a_idle_walk_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (col_q == '0 && row_q == '0))
    else $error("walk position left off origin while idle");

endmodule

/* rtl/core/sfb_fifo.sv */
// short queue of classified items between the front and back ends
module sfb_fifo
  import sfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sfb_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output sfb_item_t pop_item_o
);

  sfb_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]      count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o     = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign valid_o    = count_q != '0;
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != (FIFO_AW+1)'(FIFO_DEPTH)) |-> (FIFO_AW'(wr_ptr_q - rd_ptr_q) == count_q[FIFO_AW-1:0]))
    else $error("queue count out of step with pointers");

endmodule

/* rtl/core/sfb_back.sv */
// back end: two-stage sheet address pipeline whose second stage is the output register
module sfb_back
  import sfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfb_cfg_t  cfg_i,
  input  logic      valid_i,
  input  sfb_item_t item_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [ADDR_W-1:0]  out_src_o,
  output logic               out_we_o,
  output logic [ADDR_W-1:0]  out_dest_o,
  output logic [PIXEL_W-1:0] out_colour_o,
  output logic               out_last_o
);

  logic                        s1_valid_q, s1_valid_d;
  sfb_item_t                   s1_item_q;
  logic [ADDR_W-1:0]           s1_col_sum_q, s1_row_sum_q;
  logic [FIDX_W+SIZE_W-1:0]    col_prod, row_prod;
  logic [ADDR_W+SIZE_W-1:0]    row_addr;
  logic [ADDR_W-1:0]           src;

  logic                        out_valid_q;
  logic [ADDR_W-1:0]           out_src_q, out_dest_q;
  logic                        out_we_q, out_last_q;
  logic [PIXEL_W-1:0]          out_colour_q;

  logic                        advance, load_out;

  assign advance  = !out_valid_q || out_ready_i;
  assign load_out = s1_valid_q && advance;
  assign pop_o    = valid_i && (!s1_valid_q || load_out);

  assign col_prod = cfg_i.frame_col * clamp_size(cfg_i.frame_width);
  assign row_prod = cfg_i.frame_row * clamp_size(cfg_i.frame_height);
  assign row_addr = s1_row_sum_q * cfg_i.sheet_width;
  assign src      = row_addr[ADDR_W-1:0] + s1_col_sum_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (load_out) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q    <= item_i;
      s1_col_sum_q <= ADDR_W'(col_prod) + ADDR_W'(item_i.col);
      s1_row_sum_q <= ADDR_W'(row_prod) + ADDR_W'(item_i.row);
    end
    if (load_out) begin
      out_src_q    <= s1_item_q.has_src ? src : '0;
      out_we_q     <= s1_item_q.we;
      out_dest_q   <= s1_item_q.dest;
      out_colour_q <= s1_item_q.colour;
      out_last_q   <= s1_item_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_src_o    = out_src_q;
  assign out_we_o     = out_we_q;
  assign out_dest_o   = out_dest_q;
  assign out_colour_o = out_colour_q;
  assign out_last_o   = out_last_q;

  a_last_has_no_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_src_q == '0))
    else $error("last pixel carries a fetch address");

  a_masked_no_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_we_q) |-> (out_dest_q == '0))
    else $error("screen address present on a masked pixel");

endmodule

/* rtl/core/sprite_frame_blitter.sv */
// top level of the sprite frame blitter: register file, front, queue, back
// path: an accepted item is written into the queue, then the stage-one register, then the output register
// throughput: one item per cycle while the output is not stalled; the front walk update and the two-stage
//   sheet address multiply (frame offset, then row times sheet width) set it
// the four-entry queue lets the front keep taking items while the output stalls, until the queue is full
// reset: walk, busy flag, queue and pipeline valids clear; registers take their reset values
module sprite_frame_blitter
  import sfb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // pixel
  input  logic                  s_axis_tuser,  // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,  // source_address, dest_address, colour
  output logic                  m_axis_tuser,  // write_enable
  output logic                  m_axis_tlast
);

  sfb_cfg_t  cfg_q;
  logic      push, full, pop, q_valid;
  sfb_item_t push_item, pop_item;

  logic [ADDR_W-1:0]  out_src, out_dest;
  logic [PIXEL_W-1:0] out_colour;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x        <= '0;
      cfg_q.pos_y        <= '0;
      cfg_q.frame_col    <= '0;
      cfg_q.frame_row    <= '0;
      cfg_q.frame_width  <= SIZE_W'(1);
      cfg_q.frame_height <= SIZE_W'(1);
      cfg_q.sheet_width  <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POS_X:        cfg_q.pos_x        <= cfg_data_i[POS_W-1:0];
        CFG_POS_Y:        cfg_q.pos_y        <= cfg_data_i[POS_W-1:0];
        CFG_FRAME_COL:    cfg_q.frame_col    <= cfg_data_i[FIDX_W-1:0];
        CFG_FRAME_ROW:    cfg_q.frame_row    <= cfg_data_i[FIDX_W-1:0];
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[SIZE_W-1:0];
        CFG_SHEET_WIDTH:  cfg_q.sheet_width  <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .in_pixel_i  (s_axis_tdata),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  sfb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  sfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (q_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_src_o    (out_src),
    .out_we_o     (m_axis_tuser),
    .out_dest_o   (out_dest),
    .out_colour_o (out_colour),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_colour, out_dest, out_src};

endmodule

/* tb/sv/sprite_frame_blitter_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the sprite frame blitter: directed and random blits against a predictor
module sprite_frame_blitter_tb;
  import sfb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    sfb_op_e     op;
    logic [31:0] pix;
  } feed_item_t;

  typedef struct packed {
    logic [19:0] src;
    logic        we;
    logic [19:0] dest;
    logic [31:0] colour;
    logic        last;
  } blit_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  sprite_frame_blitter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow registers and walk state
  logic [11:0] sh_pos_x = '0;
  logic [11:0] sh_pos_y = '0;
  logic [9:0]  sh_fcol = '0;
  logic [9:0]  sh_frow = '0;
  logic [10:0] sh_fw = 11'd1;
  logic [10:0] sh_fh = 11'd1;
  logic [10:0] sh_sw = 11'd1;
  logic [9:0]  walk_col = '0;
  logic [9:0]  walk_row = '0;
  logic        blit_busy = 1'b0;

  feed_item_t   feed_q[$];
  blit_result_t pending_results[$];
  feed_item_t   nxt;
  blit_result_t want;
  logic         in_taken = 1'b0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  int           errors = 0;
  int           cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int eff_size(input logic [10:0] v);
    if (v == '0) return 1;
    if (v > WALK_MAX) return WALK_MAX;
    return int'(v);
  endfunction

  function automatic logic [19:0] sheet_addr(input int col, input int row);
    longint a;
    a = longint'(sh_fcol) * eff_size(sh_fw) + col
      + (longint'(sh_frow) * eff_size(sh_fh) + row) * longint'(sh_sw);
    return a[19:0];
  endfunction

  function automatic blit_result_t blit_step(input sfb_op_e op, input logic [31:0] pix);
    blit_result_t r;
    int           x;
    int           y;
    int           fw;
    int           fh;
    bit           last_px;
    r = '0;
    if (op == OP_START) begin
      walk_col = '0;
      walk_row = '0;
      blit_busy = 1'b1;
      r.src = sheet_addr(0, 0);
    end else if (blit_busy) begin
      fw = eff_size(sh_fw);
      fh = eff_size(sh_fh);
      x = int'($signed(sh_pos_x)) + int'(walk_col);
      y = int'($signed(sh_pos_y)) + int'(walk_row);
      if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT &&
          pix[31:ALPHA_LSB] != '0) begin
        r.we = 1'b1;
        r.dest = 20'(x + y * SCREEN_WIDTH);
      end
      r.colour = pix;
      if (int'(walk_col) + 1 >= fw) begin
        walk_col = '0;
        walk_row = walk_row + 10'd1;
        last_px = (walk_row == '0) || (int'(walk_row) >= fh);
      end else begin
        walk_col = walk_col + 10'd1;
        last_px = 1'b0;
      end
      if (last_px) begin
        r.last = 1'b1;
        walk_col = '0;
        walk_row = '0;
        blit_busy = 1'b0;
      end else begin
        r.src = sheet_addr(int'(walk_col), int'(walk_row));
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (errors < 40) $display("mismatch %s: got %h want %h", field, got, exp_val);
    errors++;
  endtask

  // source side and sink stalls
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (rst_ni && feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.op;
        s_axis_tdata  <= nxt.pix;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // prediction on accepted items, checking on accepted results
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (rst_ni) begin
        if (s_axis_tvalid && s_axis_tready)
          pending_results.push_back(blit_step(sfb_op_e'(s_axis_tuser), s_axis_tdata));
        if (m_axis_tvalid && m_axis_tready) begin
          if (pending_results.size() == 0) begin
            flag_mismatch("unexpected item", m_axis_tdata[31:0], '0);
          end else begin
            want = pending_results.pop_front();
            if (m_axis_tdata[19:0] != want.src)
              flag_mismatch("source_address", 32'(m_axis_tdata[19:0]), 32'(want.src));
            if (m_axis_tuser != want.we)
              flag_mismatch("write_enable", 32'(m_axis_tuser), 32'(want.we));
            if (m_axis_tdata[39:20] != want.dest)
              flag_mismatch("dest_address", 32'(m_axis_tdata[39:20]), 32'(want.dest));
            if (m_axis_tdata[71:40] != want.colour)
              flag_mismatch("colour", m_axis_tdata[71:40], want.colour);
            if (m_axis_tlast != want.last)
              flag_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
          end
        end
      end
    end
  end

  task automatic feed(input sfb_op_e op, input logic [31:0] pix);
    feed_item_t it;
    it.op = op;
    it.pix = pix;
    feed_q.push_back(it);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_POS_X:        sh_pos_x = val;
      CFG_POS_Y:        sh_pos_y = val;
      CFG_FRAME_COL:    sh_fcol = val[9:0];
      CFG_FRAME_ROW:    sh_frow = val[9:0];
      CFG_FRAME_WIDTH:  sh_fw = val[10:0];
      CFG_FRAME_HEIGHT: sh_fh = val[10:0];
      CFG_SHEET_WIDTH:  sh_sw = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [11:0] px, input logic [11:0] py,
                         input logic [11:0] fc, input logic [11:0] fr,
                         input logic [11:0] fw, input logic [11:0] fh,
                         input logic [11:0] sw);
    set_reg(CFG_POS_X, px);
    set_reg(CFG_POS_Y, py);
    set_reg(CFG_FRAME_COL, fc);
    set_reg(CFG_FRAME_ROW, fr);
    set_reg(CFG_FRAME_WIDTH, fw);
    set_reg(CFG_FRAME_HEIGHT, fh);
    set_reg(CFG_SHEET_WIDTH, sw);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
      default: begin src_idle_pct = 9; sink_stall_pct = 9; end
    endcase
  endtask

  task automatic drain();
    while (feed_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(3) == 0) p[31:24] = '0;
    return p;
  endfunction

  // half of the picks near the screen edges so that clipping flips inside a frame
  function automatic logic [11:0] pick_pos();
    case ($urandom_range(3))
      0: return 12'($urandom);
      1: return 12'(-int'($urandom_range(12)));
      2: return 12'(SCREEN_WIDTH - int'($urandom_range(12)));
      default: return 12'($urandom_range(SCREEN_WIDTH - 1));
    endcase
  endfunction

  function automatic logic [11:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 88) return {1'($urandom), 11'($urandom_range(8))};
    if (r < 96) return {1'($urandom), 11'($urandom_range(40, 9))};
    return {1'($urandom), 11'($urandom_range(2047, 1024))};
  endfunction

  task automatic random_phase(input int m);
    int n;
    int r;
    int frame_px;
    set_mode(m);
    set_all(pick_pos(), pick_pos(), 12'($urandom), 12'($urandom), pick_size(),
            pick_size(), 12'($urandom));
    n = 0;
    while (n < 40) begin
      r = $urandom_range(99);
      if (r < 80) begin
        frame_px = eff_size(sh_fw) * eff_size(sh_fh);
        if (frame_px > 48) frame_px = $urandom_range(48);
        else if ($urandom_range(9) == 0) frame_px = $urandom_range(frame_px - 1);
        feed(OP_START, $urandom);
        repeat (frame_px) feed(OP_PIXEL, rand_pixel());
        n += frame_px + 1;
      end else if (r < 92) begin
        feed(OP_PIXEL, rand_pixel());
        n++;
      end else begin
        feed(OP_START, $urandom);
        n++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, pixels while idle
    set_mode(0);
    feed(OP_PIXEL, 32'hFFFF_FFFF);
    feed(OP_START, 32'h0);
    feed(OP_PIXEL, 32'hFF00_0000);
    feed(OP_PIXEL, 32'h0000_0000);
    drain();

    // left clip, alpha extremes, restart while busy
    set_all(12'hFFF, 12'h000, 12'h3FF, 12'h3FF, 12'd3, 12'd2, 12'd1024);
    feed(OP_START, 32'h0);
    feed(OP_PIXEL, 32'h00FF_FFFF);
    feed(OP_PIXEL, 32'h0100_0000);
    feed(OP_START, 32'hFFFF_FFFF);
    feed(OP_PIXEL, 32'h8012_3456);
    feed(OP_PIXEL, 32'hFFFF_FFFF);
    feed(OP_PIXEL, 32'h0000_0000);
    feed(OP_PIXEL, 32'h7FAB_CDEF);
    feed(OP_PIXEL, 32'hFE00_0001);
    feed(OP_PIXEL, 32'h0155_AAAA);
    drain();

    // bottom right corner, zero width, oversized height, zero sheet width
    set_mode(2);
    set_all(12'h3FF, 12'h3FF, 12'h000, 12'h005, 12'h000, 12'h7FF, 12'h000);
    feed(OP_START, 32'h0);
    feed(OP_PIXEL, 32'hFFFF_FFFF);
    feed(OP_PIXEL, 32'hFFFF_FFFF);
    feed(OP_PIXEL, 32'h8000_0000);
    drain();

    // frame shrinks under a walk that is still running
    set_mode(1);
    set_all(12'h800, 12'h7FF, 12'h000, 12'h000, 12'd2, 12'd1, 12'd2047);
    feed(OP_PIXEL, 32'hFFFF_FFFF);
    feed(OP_START, 32'h0);
    feed(OP_PIXEL, 32'h1234_5678);
    feed(OP_PIXEL, 32'h9ABC_DEF0);
    drain();

    // oversized width clamps, then full height frame whose row walk wraps
    set_mode(3);
    set_all(12'hFFB, 12'h000, 12'h001, 12'h002, 12'd2047, 12'd0, 12'd1);
    feed(OP_START, 32'h0);
    repeat (40) feed(OP_PIXEL, rand_pixel());
    drain();
    set_mode(0);
    set_all(12'd1020, 12'hFFD, 12'h3FF, 12'h001, 12'd1, 12'd1024, 12'd1023);
    feed(OP_START, 32'h0);
    repeat (1024) feed(OP_PIXEL, rand_pixel());
    drain();

    for (int ph = 0; ph < 6; ph++) random_phase(ph);

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
